/* src/pse_pkg.sv */
package pse_pkg;

    // Stack geometry and word size
    localparam int STACK_DEPTH  = 64;
    localparam int WORD_BITS    = 48;
    localparam int SP_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_BITS    = $clog2(STACK_DEPTH);

    // Multiplier digit size and step count
    localparam int MUL_DIGIT    = (WORD_BITS < 16) ? WORD_BITS : 16;
    localparam int MUL_STEPS    = (WORD_BITS + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MUL_CNT_BITS = $clog2(MUL_STEPS + 1);

    // Divider iteration counter
    localparam int DIV_CNT_BITS = $clog2(WORD_BITS + 1);

    // Token kinds
    typedef enum logic [2:0] {
        FN_PUSH = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4
    } func_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Source of a new top-of-stack value
    typedef enum logic [2:0] {
        TS_OPERAND = 3'd0,
        TS_ADD     = 3'd1,
        TS_SUB     = 3'd2,
        TS_MUL     = 3'd3,
        TS_DIV     = 3'd4,
        TS_ZERO    = 3'd5
    } tos_src_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_FETCH  = 3'd2,
        S_MUL    = 3'd3,
        S_MULWR  = 3'd4,
        S_DIV    = 3'd5,
        S_FINISH = 3'd6
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     tok_load;
        logic     push;
        logic     pop;
        logic     tos_wr;
        tos_src_t tos_src;
        logic     flag_en;
        status_t  flag_code;
        logic     rd_issue;
        logic     mul_start;
        logic     mul_step;
        logic     div_start;
        logic     emit;
    } pse_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       last;
        logic       sp_full;
        logic       sp_lt2;
        logic       tos_zero;
        logic       mul_last;
        logic       div_done;
        logic       out_free;
    } pse_sts_t;

endpackage

/* src/pse_token_if.sv */
interface pse_token_if
    import pse_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [2:0]           func;
    logic [WORD_BITS-1:0] operand;
    logic                 end_of_expr;

    modport source (output valid, output func, output operand, output end_of_expr,
                    input ready);
    modport sink   (input valid, input func, input operand, input end_of_expr,
                    output ready);
endinterface

/* src/pse_result_if.sv */
interface pse_result_if
    import pse_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] answer;
    logic [2:0]           status;

    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

/* src/pse_div.sv */
module pse_div
    import pse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] dividend,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 done,
    output logic [WORD_BITS-1:0] quotient
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WORD_BITS-1:0]    quo_reg, quo_next;
    logic [WORD_BITS-1:0]    rem_reg, rem_next;
    logic [WORD_BITS-1:0]    mag_d_reg, mag_d_next;
    logic                    neg_reg, neg_next;

    logic [WORD_BITS:0]      shifted;
    logic [WORD_BITS:0]      diff;
    logic                    fits;

    // Trial subtract of one quotient bit
    assign shifted = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff    = shifted - {1'b0, mag_d_reg};
    assign fits    = ~diff[WORD_BITS];

    // Load magnitudes on start, then shift one bit a cycle
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        mag_d_next = mag_d_reg;
        neg_next   = neg_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            cnt_next   = '0;
            quo_next   = dividend[WORD_BITS-1] ? (WORD_BITS'(0) - dividend) : dividend;
            rem_next   = '0;
            mag_d_next = divisor[WORD_BITS-1] ? (WORD_BITS'(0) - divisor) : divisor;
            neg_next   = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(WORD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold working values
    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        mag_d_reg <= mag_d_next;
        neg_reg   <= neg_next;
    end

    // Restore the sign of the quotient
    assign done     = done_reg;
    assign quotient = neg_reg ? (WORD_BITS'(0) - quo_reg) : quo_reg;

endmodule

/* src/pse_dpath.sv */
module pse_dpath
    import pse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pse_cmd_t             cmd,
    output pse_sts_t             sts,
    input  logic [2:0]           tok_func,
    input  logic [WORD_BITS-1:0] tok_operand,
    input  logic                 tok_last,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] out_answer,
    output logic [2:0]           out_status
);

    logic [2:0]              func_reg;
    logic                    last_reg;
    logic [WORD_BITS-1:0]    operand_reg;

    logic [SP_BITS-1:0]      sp_reg, sp_next;
    status_t                 err_reg, err_next;
    logic [WORD_BITS-1:0]    tos_reg, tos_next;
    logic [WORD_BITS-1:0]    rd_data_reg;
    logic [WORD_BITS-1:0]    mem [STACK_DEPTH];
    logic [SP_BITS-1:0]      sp_m1, sp_m2;

    logic [WORD_BITS-1:0]    mcand_reg, mplier_reg, acc_reg;
    logic [MUL_CNT_BITS-1:0] mul_cnt_reg, mul_cnt_next;
    logic [WORD_BITS+MUL_DIGIT-1:0] mul_prod;

    logic                    out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]    out_answer_reg;
    status_t                 out_status_reg;

    logic                    div_done;
    logic [WORD_BITS-1:0]    div_quo;

    assign sp_m1 = sp_reg - SP_BITS'(1);
    assign sp_m2 = sp_reg - SP_BITS'(2);

    // Latch the token on accept
    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
        begin
            func_reg    <= tok_func;
            last_reg    <= tok_last;
            operand_reg <= tok_operand;
        end
    end

    // Stack body below the top entry
    always_ff @(posedge clk)
    begin
        if (cmd.push && (sp_reg != '0))
            mem[sp_m1[ADDR_BITS-1:0]] <= tos_reg;
        if (cmd.rd_issue)
            rd_data_reg <= mem[sp_m2[ADDR_BITS-1:0]];
    end

    // Multiply one digit of the multiplier a step
    assign mul_prod = mcand_reg * mplier_reg[MUL_DIGIT-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mcand_reg  <= rd_data_reg;
            mplier_reg <= tos_reg;
            acc_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            mcand_reg  <= mcand_reg << MUL_DIGIT;
            mplier_reg <= mplier_reg >> MUL_DIGIT;
            acc_reg    <= acc_reg + mul_prod[WORD_BITS-1:0];
        end
    end

    always_comb
    begin
        mul_cnt_next = mul_cnt_reg;
        if (cmd.mul_start)
            mul_cnt_next = '0;
        else if (cmd.mul_step)
            mul_cnt_next = mul_cnt_reg + MUL_CNT_BITS'(1);
    end

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Select the new top of stack
    always_comb
    begin
        tos_next = tos_reg;
        if (cmd.tos_wr)
        begin
            unique case (cmd.tos_src)
                TS_OPERAND: tos_next = operand_reg;
                TS_ADD:     tos_next = rd_data_reg + tos_reg;
                TS_SUB:     tos_next = rd_data_reg - tos_reg;
                TS_MUL:     tos_next = acc_reg;
                TS_DIV:     tos_next = div_quo;
                TS_ZERO:    tos_next = '0;
                default:    tos_next = tos_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg <= tos_next;
    end

    // Advance the stack pointer and keep the first error; emit clears both
    always_comb
    begin
        sp_next  = sp_reg;
        err_next = err_reg;
        priority if (cmd.emit)
        begin
            sp_next  = '0;
            err_next = ST_OK;
        end
        else
        begin
            if (cmd.push)
                sp_next = sp_reg + SP_BITS'(1);
            else if (cmd.pop)
                sp_next = sp_m1;
            if (cmd.flag_en && (err_reg == ST_OK))
                err_next = cmd.flag_code;
        end
    end

    // Output register: load on emit, drop when taken
    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            priority if (err_reg != ST_OK)
            begin
                out_answer_reg <= '0;
                out_status_reg <= err_reg;
            end
            else if (sp_reg == '0)
            begin
                out_answer_reg <= '0;
                out_status_reg <= ST_EMPTY;
            end
            else
            begin
                out_answer_reg <= tos_reg;
                out_status_reg <= ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            err_reg       <= ST_OK;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Report status to the controller
    assign sts.func     = func_reg;
    assign sts.last     = last_reg;
    assign sts.sp_full  = (sp_reg >= SP_BITS'(STACK_DEPTH));
    assign sts.sp_lt2   = (sp_reg < SP_BITS'(2));
    assign sts.tos_zero = (tos_reg == '0);
    assign sts.mul_last = (mul_cnt_reg == MUL_CNT_BITS'(MUL_STEPS - 1));
    assign sts.div_done = div_done;
    assign sts.out_free = ~out_valid_reg | out_ready;

    assign out_valid  = out_valid_reg;
    assign out_answer = out_answer_reg;
    assign out_status = out_status_reg;

endmodule

/* src/pse_ctrl.sv */
module pse_ctrl
    import pse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pse_sts_t sts,
    output pse_cmd_t cmd,
    output state_t   state
);

    state_t state_reg, state_next;
    logic   is_op;

    assign is_op = (sts.func == FN_ADD) || (sts.func == FN_SUB) ||
                   (sts.func == FN_MUL) || (sts.func == FN_DIV);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
                state_next = (is_op && !sts.sp_lt2) ? S_FETCH : S_FINISH;
            S_FETCH:
                priority if (sts.func == FN_MUL)
                    state_next = S_MUL;
                else if ((sts.func == FN_DIV) && !sts.tos_zero)
                    state_next = S_DIV;
                else
                    state_next = S_FINISH;
            S_MUL:
                if (sts.mul_last)
                    state_next = S_MULWR;
            S_MULWR:
                state_next = S_FINISH;
            S_DIV:
                if (sts.div_done)
                    state_next = S_FINISH;
            S_FINISH:
                if (!sts.last || sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.tok_load = in_valid;
            end
            S_DECODE:
            begin
                unique case (sts.func)
                    FN_PUSH:
                        if (sts.sp_full)
                        begin
                            cmd.flag_en   = 1'b1;
                            cmd.flag_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push    = 1'b1;
                            cmd.tos_wr  = 1'b1;
                            cmd.tos_src = TS_OPERAND;
                        end
                    FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                        if (sts.sp_lt2)
                        begin
                            cmd.flag_en   = 1'b1;
                            cmd.flag_code = ST_UNDERFLOW;
                        end
                        else
                            cmd.rd_issue = 1'b1;
                    default:
                        cmd.rd_issue = 1'b0;
                endcase
            end
            S_FETCH:
            begin
                unique case (sts.func)
                    FN_ADD:
                    begin
                        cmd.tos_wr  = 1'b1;
                        cmd.tos_src = TS_ADD;
                        cmd.pop     = 1'b1;
                    end
                    FN_SUB:
                    begin
                        cmd.tos_wr  = 1'b1;
                        cmd.tos_src = TS_SUB;
                        cmd.pop     = 1'b1;
                    end
                    FN_MUL:
                        cmd.mul_start = 1'b1;
                    FN_DIV:
                        if (sts.tos_zero)
                        begin
                            cmd.tos_wr    = 1'b1;
                            cmd.tos_src   = TS_ZERO;
                            cmd.pop       = 1'b1;
                            cmd.flag_en   = 1'b1;
                            cmd.flag_code = ST_DIVZERO;
                        end
                        else
                            cmd.div_start = 1'b1;
                    default:
                        cmd.pop = 1'b0;
                endcase
            end
            S_MUL:
                cmd.mul_step = 1'b1;
            S_MULWR:
            begin
                cmd.tos_wr  = 1'b1;
                cmd.tos_src = TS_MUL;
                cmd.pop     = 1'b1;
            end
            S_DIV:
                if (sts.div_done)
                begin
                    cmd.tos_wr  = 1'b1;
                    cmd.tos_src = TS_DIV;
                    cmd.pop     = 1'b1;
                end
            S_FINISH:
                cmd.emit = sts.last && sts.out_free;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

/* src/postfix_stack_evaluator.sv */
// Postfix (RPN) evaluator on a signed operand stack of STACK_DEPTH words.
// token channel: one item per token (func, operand, end_of_expr). A number
// token pushes operand; add, subtract, multiply and divide pop two entries
// and push earlier op later, wrapped to WORD_BITS, division toward zero.
// result channel: one item per expression, on the token marked end_of_expr,
// carrying the top of stack and a status (underflow, overflow, divide by
// zero and empty stack are sticky until the end of the expression).
// A token is fully worked before the next is accepted. Multiply runs
// MUL_STEPS digit steps, one 48x16 partial product a cycle; divide takes one
// quotient bit a cycle in the restoring divider. The stack body lives in a
// single-port memory with a registered read; the top entry sits in a register.
// The result waits in an output register, so the next token is accepted
// while it is unread. If the receiver stalls and a second final token
// arrives, the block holds that token until the first result is taken.
// Reset empties the stack and clears the error; the memory is not cleared.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pse_token_if.sink    token,
    pse_result_if.source result
);

    pse_cmd_t cmd;
    pse_sts_t sts;
    state_t   state;

    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (token.valid),
        .in_ready (token.ready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    pse_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .tok_func    (token.func),
        .tok_operand (token.operand),
        .tok_last    (token.end_of_expr),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .out_answer  (result.answer),
        .out_status  (result.status)
    );

`ifndef SYNTHESIS
    // One token at a time: accept closes the input
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        (token.valid && token.ready) |=> !token.ready)
        else $error("token accepted while previous one still in work");

    // Emit never overwrites an unread result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted over a pending result");

    // Emit shows up on the result channel
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result.valid)
        else $error("emitted result not presented");

    // No push on a full stack
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !sts.sp_full)
        else $error("push on full stack");

    // Divider starts only in the fetch state with a nonzero divisor
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (state == S_FETCH) && !sts.tos_zero)
        else $error("divider started outside fetch or by zero");
`endif

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import pse_pkg::*;

    // Unused token kinds: the block ignores them
    localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

    localparam logic [WORD_BITS-1:0] WORD_MAX  = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] MINUS_ONE = '1;

    localparam int TOKEN_TARGET = 1750;
    localparam int DRAIN_CYCLES = 120;
    localparam int QUIET_LIMIT  = 1000;

    typedef struct {
        logic [WORD_BITS-1:0] answer;
        status_t              status;
    } expr_result_t;

    typedef struct {
        logic [2:0]           func;
        logic [WORD_BITS-1:0] operand;
        logic                 is_last;
    } token_t;

    // Stack evaluator model and queue of expected expression results
    class expr_scoreboard;
        logic [WORD_BITS-1:0] stack [STACK_DEPTH];
        int                   depth;
        status_t              err;
        expr_result_t         pending_results[$];
        int                   errors;
        int                   checked;
        int                   error_results;

        function new();
            depth         = 0;
            err           = ST_OK;
            errors        = 0;
            checked       = 0;
            error_results = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Keep the first error until the expression ends
        function void raise(status_t code);
            if (err == ST_OK)
                err = code;
        endfunction

        // Signed division, truncated toward zero, wrapped to the word
        function logic [WORD_BITS-1:0] quotient(logic [WORD_BITS-1:0] num,
                                                logic [WORD_BITS-1:0] den);
            longint sn;
            longint sd;
            longint q;
            sn = signed'(num);
            sd = signed'(den);
            q  = sn / sd;
            return q[WORD_BITS-1:0];
        endfunction

        // Apply one accepted token; queue a result on the final token
        task note_token(logic [2:0] func, logic [WORD_BITS-1:0] operand,
                        logic is_last);
            logic [WORD_BITS-1:0] later;
            logic [WORD_BITS-1:0] earlier;
            logic [WORD_BITS-1:0] value;
            expr_result_t         want;
            if (func == FN_PUSH) begin
                if (depth >= STACK_DEPTH)
                    raise(ST_OVERFLOW);
                else begin
                    stack[depth] = operand;
                    depth++;
                end
            end
            else if (func <= FN_DIV) begin
                if (depth < 2)
                    raise(ST_UNDERFLOW);
                else begin
                    later   = stack[depth-1];
                    earlier = stack[depth-2];
                    case (func)
                        FN_ADD:  value = earlier + later;
                        FN_SUB:  value = earlier - later;
                        FN_MUL:  value = earlier * later;
                        default:
                        begin
                            if (later == '0) begin
                                raise(ST_DIVZERO);
                                value = '0;
                            end
                            else
                                value = quotient(earlier, later);
                        end
                    endcase
                    depth--;
                    stack[depth-1] = value;
                end
            end
            if (is_last) begin
                if (err != ST_OK) begin
                    want.answer = '0;
                    want.status = err;
                end
                else if (depth == 0) begin
                    want.answer = '0;
                    want.status = ST_EMPTY;
                end
                else begin
                    want.answer = stack[depth-1];
                    want.status = ST_OK;
                end
                pending_results.push_back(want);
                depth = 0;
                err   = ST_OK;
            end
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic [WORD_BITS-1:0] answer, logic [2:0] status);
            expr_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result answer %0d status %0d",
                                 $signed(answer), status));
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.status != ST_OK)
                error_results++;
            if (status !== want.status)
                report($sformatf("status %0d, expected %0d", status, want.status));
            if (answer !== want.answer)
                report($sformatf("answer %0d, expected %0d",
                                 $signed(answer), $signed(want.answer)));
        endtask
    endclass

    logic clk;
    logic rst_n;

    pse_token_if  tok ();
    pse_result_if res ();

    postfix_stack_evaluator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (tok),
        .result (res)
    );

    expr_scoreboard sb = new();
    token_t         plan[$];
    int             tokens_sent;
    bit             no_gaps;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watch both channels at every edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (tok.valid && tok.ready)
                sb.note_token(tok.func, tok.operand, tok.end_of_expr);
            if (res.valid && res.ready)
                sb.check_result(res.answer, res.status);
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((tok.valid && tok.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Result receiver: stall at random, with runs of no stalling
    initial
    begin
        int stall;
        int run;
        bit fast;
        res.ready <= 1'b0;
        run  = 0;
        fast = 1'b0;
        wait (rst_n);
        forever begin
            if (run == 0) begin
                run  = $urandom_range(4, 24);
                fast = ($urandom_range(0, 2) == 0);
            end
            run--;
            stall = fast ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
        end
    end

    // Offer one token and hold it until accepted
    task automatic send_token(logic [2:0] func, logic [WORD_BITS-1:0] operand,
                              logic is_last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            tok.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok.valid       <= 1'b1;
        tok.func        <= func;
        tok.operand     <= operand;
        tok.end_of_expr <= is_last;
        do @(posedge clk); while (!tok.ready);
        if (func <= FN_DIV)
            tokens_sent++;
    endtask

    // Operand mix: extremes, small values and full-width random
    function automatic logic [WORD_BITS-1:0] rand_operand();
        logic [63:0] r;
        int          v;
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return MINUS_ONE;
            3:       return '0;
            4, 5:
            begin
                v = $urandom_range(0, 40) - 20;
                return WORD_BITS'(v);
            end
            6:       return WORD_BITS'(1);
            default:
            begin
                r = {$urandom, $urandom};
                return r[WORD_BITS-1:0];
            end
        endcase
    endfunction

    function automatic logic [2:0] rand_operator();
        return 3'($urandom_range(FN_ADD, FN_DIV));
    endfunction

    function automatic void plan_token(logic [2:0] func, logic [WORD_BITS-1:0] operand,
                                       logic is_last);
        token_t t;
        t.func    = func;
        t.operand = operand;
        t.is_last = is_last;
        plan.push_back(t);
    endfunction

    // Valid expression with random operands and operators
    function automatic void plan_wellformed();
        int n;
        int depth;
        int pushed;
        n      = $urandom_range(1, 8);
        depth  = 0;
        pushed = 0;
        while (pushed < n || depth > 1) begin
            if (pushed < n && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                plan_token(FN_PUSH, rand_operand(), 1'b0);
                pushed++;
                depth++;
            end
            else begin
                plan_token(rand_operator(), rand_operand(), 1'b0);
                depth--;
            end
            if ($urandom_range(0, 19) == 0)
                plan_token(3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)),
                           rand_operand(), 1'b0);
        end
        // Leave a second entry on the stack now and then
        if ($urandom_range(0, 7) == 0)
            plan_token(FN_PUSH, rand_operand(), 1'b0);
    endfunction

    // Fill the stack to around its depth, then a few operators
    function automatic void plan_deep();
        repeat ($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4))
            plan_token(FN_PUSH, rand_operand(), 1'b0);
        repeat ($urandom_range(0, 4))
            plan_token(rand_operator(), rand_operand(), 1'b0);
    endfunction

    // Random kinds, no attention to stack depth
    function automatic void plan_broken();
        repeat ($urandom_range(1, 6))
            plan_token(3'($urandom_range(FN_PUSH, FN_DIV)), rand_operand(), 1'b0);
    endfunction

    // Any code, end marks anywhere
    function automatic void plan_noise();
        repeat ($urandom_range(1, 6))
            plan_token(3'($urandom_range(0, 7)), rand_operand(),
                       ($urandom_range(0, 3) == 0));
    endfunction

    task automatic send_plan();
        plan[plan.size()-1].is_last = 1'b1;
        foreach (plan[i])
            send_token(plan[i].func, plan[i].operand, plan[i].is_last);
        plan.delete();
    endtask

    // Stimulus
    initial
    begin
        int pick;
        rst_n           <= 1'b0;
        tok.valid       <= 1'b0;
        tok.func        <= FN_PUSH;
        tok.operand     <= '0;
        tok.end_of_expr <= 1'b0;
        tokens_sent     = 0;
        no_gaps         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Final token on an empty stack, ignored code
        send_token(FN_SPARE_FIRST, WORD_MAX, 1'b1);
        // Add wraps past the largest value
        send_token(FN_PUSH, WORD_MAX, 1'b0);
        send_token(FN_PUSH, WORD_BITS'(1), 1'b0);
        send_token(FN_ADD, '0, 1'b1);
        // Subtract wraps past the smallest value
        send_token(FN_PUSH, WORD_MIN, 1'b0);
        send_token(FN_PUSH, WORD_BITS'(1), 1'b0);
        send_token(FN_SUB, MINUS_ONE, 1'b1);
        // Smallest value divided by minus one
        send_token(FN_PUSH, WORD_MIN, 1'b0);
        send_token(FN_PUSH, MINUS_ONE, 1'b0);
        send_token(FN_DIV, '0, 1'b1);
        // Divide by zero
        send_token(FN_PUSH, WORD_BITS'(7), 1'b0);
        send_token(FN_PUSH, '0, 1'b0);
        send_token(FN_DIV, '0, 1'b1);
        // Operator with one entry
        send_token(FN_PUSH, WORD_BITS'(5), 1'b0);
        send_token(FN_MUL, '0, 1'b1);
        // Multiply of the largest values wraps
        send_token(FN_PUSH, WORD_MAX, 1'b0);
        send_token(FN_PUSH, WORD_MAX, 1'b0);
        send_token(FN_MUL, '0, 1'b1);
        // Negative quotient truncates toward zero
        send_token(FN_PUSH, WORD_BITS'(-7), 1'b0);
        send_token(FN_PUSH, WORD_BITS'(2), 1'b0);
        send_token(FN_DIV, '0, 1'b1);
        // Two entries left, ignored code ends the expression
        send_token(FN_PUSH, WORD_BITS'(3), 1'b0);
        send_token(FN_PUSH, WORD_BITS'(4), 1'b0);
        send_token(FN_SPARE_LAST, '0, 1'b1);
        // Push and end in one token
        send_token(FN_PUSH, '0, 1'b1);

        // Random expressions, mostly well formed
        while (tokens_sent < TOKEN_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 99);
            if (pick < 72)
                plan_wellformed();
            else if (pick < 75)
                plan_deep();
            else if (pick < 88)
                plan_broken();
            else
                plan_noise();
            send_plan();
        end
        tok.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d tokens sent, %0d expression results checked", tokens_sent,
                 sb.checked);
        $display("%0d results carried an error or empty status, %0d mismatches",
                 sb.error_results, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
src/pse_pkg.sv
src/pse_token_if.sv
src/pse_result_if.sv
src/pse_div.sv
src/pse_dpath.sv
src/pse_ctrl.sv
src/postfix_stack_evaluator.sv
tb/sv/testbench.sv
